[src/lbfc_pkg.sv]
// Shared types, constants and the link word packing for the link bit flip counter.
// No dependencies; imported by lbfc_flip_calc and link_bit_flip_counter_core.
package lbfc_pkg;

    localparam int NUM_PORTS  = 5;
    localparam int WORD_BITS  = 34;
    localparam int PORT_W     = 3;
    localparam int KIND_W     = 2;
    localparam int ID_W       = 8;
    localparam int PAYLOAD_W  = 32;
    localparam int TOTAL_W    = 16;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = PORT_W + KIND_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    localparam logic [COUNT_W-1:0] WORD_BITS_C = COUNT_W'(WORD_BITS);
    localparam logic [COUNT_W-1:0] HALF_BITS_C = COUNT_W'(WORD_BITS / 2);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;

    localparam int HEAD_MARK_BIT = 32;
    localparam int TAIL_MARK_BIT = 33;

    typedef logic [WORD_BITS-1:0] link_word_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEAD = 2'd0,
        KIND_BODY = 2'd1,
        KIND_TAIL = 2'd2
    } flit_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRANSITION = 1'd0,
        REG_BUS_INVERT = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic transition_signaling;
        logic bus_invert_enable;
    } cfg_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_flips;
        logic               inverted;
        logic [COUNT_W-1:0] flip_count;
    } result_t;

    function automatic link_word_t pack_word(
        input logic [KIND_W-1:0]    kind,
        input logic [ID_W-1:0]      source_id,
        input logic [ID_W-1:0]      dest_id,
        input logic [PAYLOAD_W-1:0] payload_word
    );
        link_word_t w;
        w = '0;
        case (kind)
            KIND_HEAD: begin
                w[ID_W-1:0]      = source_id;
                w[2*ID_W-1:ID_W] = dest_id;
                w[HEAD_MARK_BIT] = 1'b1;
            end
            KIND_BODY: begin
                w[PAYLOAD_W-1:0] = payload_word;
            end
            default: begin
                w[TAIL_MARK_BIT] = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[src/lbfc_flip_calc.sv]
// Flip count for one flit: popcount of changed or set bits, bus invert choice,
// saturating running total. Combinational; depends on lbfc_pkg.
module lbfc_flip_calc
    import lbfc_pkg::*;
(
    input  link_word_t         word,
    input  link_word_t         last_word,
    input  cfg_t               cfg,
    input  logic [TOTAL_W-1:0] prior_flips,
    output result_t            result
);

    link_word_t             diff;
    logic [COUNT_W-1:0]     raw_count;
    logic                   invert;
    logic [COUNT_W-1:0]     count;
    logic [TOTAL_W:0]       sum;

    always_comb begin
        diff      = cfg.transition_signaling ? word : (word ^ last_word);
        raw_count = COUNT_W'($countones(diff));
        invert    = cfg.bus_invert_enable && (raw_count > HALF_BITS_C);
        count     = invert ? (WORD_BITS_C - raw_count) : raw_count;
        sum       = {1'b0, prior_flips} + {{(TOTAL_W + 1 - COUNT_W){1'b0}}, count};

        result.flip_count  = count;
        result.inverted    = invert;
        result.total_flips = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end

endmodule

[src/link_bit_flip_counter_core.sv]
// Link bit flip counter: one flip-count result per flit, last link word per port.
// Depends on lbfc_pkg and lbfc_flip_calc.
//
// Usage:
//   s_ channel carries one flit per transaction; m_ channel returns one result
//   per flit, in order. The cfg_ port writes transition_signaling (index 0) and
//   bus_invert_enable (index 1) at any edge with cfg_wr_en high; write it only
//   while no flit is in flight.
//   Throughput: one flit per cycle while the receiver keeps m_tready high. An
//   input register feeds the popcount, the bus invert choice and the saturating
//   add, which land in the output register together with the update of that
//   port's last link word; m_tdata is driven from the output register.
//   Receiver stall: the output register holds its result; the input register
//   still takes one more flit, then s_tready drops until m_tready returns.
//   Reset (aresetn low, synchronous): both pipeline stages empty, all stored
//   last link words zero, both configuration bits zero.
//   A port number at or above the port count compares against zero and stores
//   nothing.
module link_bit_flip_counter_core
    import lbfc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] source_id, [15:8] dest_id, [47:16] payload_word, [63:48] prior_flips
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [2:0] port, [4:3] flit_kind
    input  logic [S_TUSER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [5:0] flip_count, [21:6] total_flips, [23:22] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] inverted
    output logic [M_TUSER_W-1:0]  m_tuser
);

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [PORT_W-1:0]      in_port_reg;
    logic [KIND_W-1:0]      in_kind_reg;
    logic [ID_W-1:0]        in_source_reg;
    logic [ID_W-1:0]        in_dest_reg;
    logic [PAYLOAD_W-1:0]   in_payload_reg;
    logic [TOTAL_W-1:0]     in_prior_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_result_reg;

    link_word_t             last_word_reg [NUM_PORTS];
    logic [NUM_PORTS-1:0]   port_hit;
    link_word_t             word;
    link_word_t             last_word;
    result_t                result;

    logic                   s_accept;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRANSITION: cfg_next.transition_signaling = cfg_data[0];
                REG_BUS_INVERT: cfg_next.bus_invert_enable    = cfg_data[0];
                default: ;
            endcase
        end
        in_valid_next  = s_accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_comb begin
        word      = pack_word(in_kind_reg, in_source_reg, in_dest_reg, in_payload_reg);
        last_word = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            port_hit[i] = ({{(32 - PORT_W){1'b0}}, in_port_reg} == 32'(i));
            if (port_hit[i]) begin
                last_word = last_word_reg[i];
            end
        end
    end

    lbfc_flip_calc u_flip_calc (
        .word        (word),
        .last_word   (last_word),
        .cfg         (cfg_reg),
        .prior_flips (in_prior_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the input stage until it moves on, and load its result into the output stage when it does
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_source_reg  <= s_tdata[ID_W-1:0];
            in_dest_reg    <= s_tdata[2*ID_W-1:ID_W];
            in_payload_reg <= s_tdata[2*ID_W+PAYLOAD_W-1:2*ID_W];
            in_prior_reg   <= s_tdata[2*ID_W+PAYLOAD_W+TOTAL_W-1:2*ID_W+PAYLOAD_W];
            in_port_reg    <= s_tuser[PORT_W-1:0];
            in_kind_reg    <= s_tuser[PORT_W+KIND_W-1:PORT_W];
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (!aresetn) begin
                last_word_reg[i] <= '0;
            end else if (advance && port_hit[i]) begin
                last_word_reg[i] <= word;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - TOTAL_W - COUNT_W){1'b0}},
                       out_result_reg.total_flips, out_result_reg.flip_count};
    assign m_tuser  = out_result_reg.inverted;

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_result_reg.flip_count <= WORD_BITS_C))
        else $error("flip count above link width");

    a_invert_cheaper: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result_reg.inverted) |->
            (cfg_reg.bus_invert_enable && (out_result_reg.flip_count < HALF_BITS_C)))
        else $error("inverted result without bus invert or not cheaper");

    a_total_covers_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_result_reg.total_flips >=
            {{(TOTAL_W - COUNT_W){1'b0}}, out_result_reg.flip_count}))
        else $error("total flips below this hop's count");

    a_word_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && port_hit[0]) |=> (last_word_reg[0] == $past(word)))
        else $error("last link word not updated");
`endif

endmodule
